### design/pulse_width_one_wire_sender_defines.svh
// ----------------------------------------------------------------------------
// pulse width one-wire sender assertion macros
// shared concurrent assertion forms, clocked on clk and held off in rst
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_ONE_WIRE_SENDER_DEFINES_SVH
`define PULSE_WIDTH_ONE_WIRE_SENDER_DEFINES_SVH

// same-cycle implication
`define PWOW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWOW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pwow_pkg.sv
// ----------------------------------------------------------------------------
// pwow_pkg
// types, constants and helpers of the pulse width one-wire sender
// ----------------------------------------------------------------------------
package pwow_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int COUNTER_BITS = 13;

  localparam int QA_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W    = COUNTER_BITS;
  localparam int REG_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int BIT_W    = $clog2(BYTE_W);
  localparam int QCOUNT_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BYTE_W - 1);

  localparam logic [REG_W-1:0] START_LOW_RST = REG_W'(5000);
  localparam logic [REG_W-1:0] SHORT_RST     = REG_W'(200);
  localparam logic [REG_W-1:0] LONG_RST      = REG_W'(600);

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LOW = 2'd0,
    REG_SHORT     = 2'd1,
    REG_LONG      = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_HIGH  = 4'b0100,
    PH_LOW   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] start_low;
    logic [REG_W-1:0] short_ph;
    logic [REG_W-1:0] long_ph;
  } cfg_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill_next;
    logic              dropped;
  } q_stat_t;

  typedef struct packed {
    logic line_next;
    logic sending_next;
  } fr_stat_t;

  typedef struct packed {
    logic                line_level;
    logic                sending;
    logic [QCOUNT_W-1:0] queued_count;
    logic                dropped;
  } result_t;

  function automatic logic [QA_W-1:0] qa_inc(input logic [QA_W-1:0] a);
    return (a == QA_W'(QUEUE_DEPTH - 1)) ? '0 : a + QA_W'(1);
  endfunction

endpackage

### design/pwow_ifs.sv
// ----------------------------------------------------------------------------
// pwow channel interfaces
// request, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface pwow_req_if import pwow_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, req_type, write_byte, input ready);
  modport sink   (input valid, req_type, write_byte, output ready);
endinterface

interface pwow_rsp_if import pwow_pkg::*;;
  logic                valid;
  logic                ready;
  logic                line_level;
  logic                sending;
  logic [QCOUNT_W-1:0] queued_count;
  logic                dropped;

  modport source (output valid, line_level, sending, queued_count, dropped, input ready);
  modport sink   (input valid, line_level, sending, queued_count, dropped, output ready);
endinterface

interface pwow_cfg_if import pwow_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [REG_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### design/pwow_ram.sv
// ----------------------------------------------------------------------------
// pwow_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pwow_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pwow_queue.sv
// ----------------------------------------------------------------------------
// pwow_queue
// circular byte queue held in ram, head byte read on pop through the registered ram port
// ----------------------------------------------------------------------------
`include "pulse_width_one_wire_sender_defines.svh"

module pwow_queue import pwow_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [BYTE_W-1:0] push_byte,
  input  logic              pop,
  output logic              not_empty,
  output logic [BYTE_W-1:0] head_byte,
  output q_stat_t           stat
);

  logic [QA_W-1:0]   head;
  logic [QA_W-1:0]   tail;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              full;
  logic              wr_en;

  assign full      = (fill == FILL_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign wr_en     = push && !full;

  always_comb begin
    fill_next = fill;
    if (wr_en) begin
      fill_next = fill + FILL_W'(1);
    end else if (pop) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  assign stat.fill_next = fill_next;
  assign stat.dropped   = push && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (wr_en) begin
        tail <= qa_inc(tail);
      end
      if (pop) begin
        head <= qa_inc(head);
      end
    end
  end

  pwow_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (push_byte),
    .re    (pop),
    .raddr (head),
    .rdata (head_byte)
  );

  `PWOW_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_W'(QUEUE_DEPTH), "queue fill over depth")
  `PWOW_ASSERT_NOW(a_pop_nonempty, pop, not_empty && !push, "pop from empty queue")
  `PWOW_ASSERT_NOW(a_ptr_match, fill == '0 || full, head == tail, "queue pointers disagree with fill")

endmodule

### design/pwow_framer.sv
// ----------------------------------------------------------------------------
// pwow_framer
// frame timing: start pulse, eight pulse width bits, idle tick
// ----------------------------------------------------------------------------
`include "pulse_width_one_wire_sender_defines.svh"

module pwow_framer import pwow_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  cfg_t              cfg,
  input  logic              q_not_empty,
  input  logic [BYTE_W-1:0] q_head_byte,
  output logic              pop,
  output fr_stat_t          stat
);

  phase_t            phase, phase_next;
  logic [BIT_W-1:0]  bit_pos, bit_pos_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [CNT_W-1:0]  cnt, cnt_next, cnt_inc;
  logic              line, line_next;
  logic              load_pending;
  logic [REG_W-1:0]  dur;
  logic              done;

  assign cnt_inc = cnt + CNT_W'(1);

  always_comb begin
    unique case (phase)
      PH_START: dur = cfg.start_low;
      PH_HIGH:  dur = shift_byte[0] ? cfg.long_ph : cfg.short_ph;
      PH_LOW:   dur = shift_byte[0] ? cfg.short_ph : cfg.long_ph;
      default:  dur = cfg.start_low;
    endcase
  end

  assign done = (32'(cnt_inc) >= 32'(dur));

  always_comb begin
    phase_next      = phase;
    bit_pos_next    = bit_pos;
    shift_byte_next = shift_byte;
    cnt_next        = cnt;
    line_next       = line;
    pop             = 1'b0;
    if (tick) begin
      unique case (phase)
        PH_IDLE: begin
          if (q_not_empty) begin
            pop          = 1'b1;
            phase_next   = PH_START;
            cnt_next     = '0;
            bit_pos_next = '0;
            line_next    = 1'b0;
          end
        end
        PH_START: begin
          cnt_next = cnt_inc;
          if (done) begin
            phase_next   = PH_HIGH;
            cnt_next     = '0;
            bit_pos_next = '0;
            line_next    = 1'b1;
          end
        end
        PH_HIGH: begin
          cnt_next = cnt_inc;
          if (done) begin
            phase_next = PH_LOW;
            cnt_next   = '0;
            line_next  = 1'b0;
          end
        end
        PH_LOW: begin
          cnt_next = cnt_inc;
          if (done) begin
            cnt_next  = '0;
            line_next = 1'b1;
            if (bit_pos == BIT_LAST) begin
              phase_next   = PH_IDLE;
              bit_pos_next = '0;
            end else begin
              phase_next      = PH_HIGH;
              bit_pos_next    = bit_pos + BIT_W'(1);
              shift_byte_next = shift_byte >> 1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    // popped byte lands from the ram in the cycle after the pop, still in the start pulse
    if (load_pending) begin
      shift_byte_next = q_head_byte;
    end
  end

  assign stat.line_next    = line_next;
  assign stat.sending_next = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_pos      <= '0;
      shift_byte   <= '0;
      cnt          <= '0;
      line         <= 1'b1;
      load_pending <= 1'b0;
    end else begin
      phase        <= phase_next;
      bit_pos      <= bit_pos_next;
      shift_byte   <= shift_byte_next;
      cnt          <= cnt_next;
      line         <= line_next;
      load_pending <= pop;
    end
  end

  `PWOW_ASSERT_NEXT(a_pop_loads, pop, load_pending && phase == PH_START, "popped byte not loaded")
  `PWOW_ASSERT_NOW(a_load_in_start, load_pending, phase == PH_START, "byte load outside start pulse")
  `PWOW_ASSERT_NOW(a_idle_high, phase == PH_IDLE, line, "line low while idle")

endmodule

### design/pwow_outbuf.sv
// ----------------------------------------------------------------------------
// pwow_outbuf
// two entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module pwow_outbuf import pwow_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    space,
  pwow_rsp_if.source rsp
);

  logic    v0, v1;
  result_t d0, d1;
  logic    take;

  assign take  = v0 && rsp.ready;
  assign space = !v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (v1) begin
        if (take) begin
          v1 <= 1'b0;
        end
      end else if (push) begin
        if (!v0 || take) begin
          v0 <= 1'b1;
        end else begin
          v1 <= 1'b1;
        end
      end else if (take) begin
        v0 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      if (take) begin
        d0 <= d1;
      end
    end else if (push) begin
      if (!v0 || take) begin
        d0 <= din;
      end else begin
        d1 <= din;
      end
    end
  end

  assign rsp.valid        = v0;
  assign rsp.line_level   = d0.line_level;
  assign rsp.sending      = d0.sending;
  assign rsp.queued_count = d0.queued_count;
  assign rsp.dropped      = d0.dropped;

endmodule

### design/pulse_width_one_wire_sender.sv
// ----------------------------------------------------------------------------
// pulse_width_one_wire_sender
// queues bytes and sends them as pulse width coded frames on one line
// ----------------------------------------------------------------------------
// req carries either a byte to queue (req_type 0) or one time tick (req_type 1).
// every request transfer yields exactly one result on rsp: the line level,
// the sending flag and the queue count after that request, plus a dropped
// flag for a write that found the 32 entry queue full.
// cfg writes the start, short and long phase lengths (index 0, 1, 2); it is
// always ready and an unknown index is ignored.
// a result is registered in the output buffer before it is valid on rsp.
// throughput: one request per cycle while the result buffer has space.
// the popped byte is read from the queue ram on the tick that opens a frame
// and lands in the shift register during the start pulse.
// reset: line high, queue empty, phase lengths 5000 / 200 / 600 ticks; no
// request is taken while rst is high.
// rsp stall: results pile up in a two entry buffer; req.ready drops once
// both entries are full and returns as soon as rsp takes one.
// ----------------------------------------------------------------------------
module pulse_width_one_wire_sender import pwow_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pwow_req_if.sink   req,
  pwow_rsp_if.source rsp,
  pwow_cfg_if.sink   cfg
);

  cfg_t              regs;
  logic              space;
  logic              accept;
  logic              tick;
  logic              push;
  logic              pop;
  logic              q_not_empty;
  logic [BYTE_W-1:0] q_head_byte;
  q_stat_t           q_stat;
  fr_stat_t          fr_stat;
  result_t           res;

  assign req.ready = space && !rst;
  assign cfg.ready = 1'b1;

  assign accept = req.valid && req.ready;
  assign tick   = accept && (req.req_type == REQ_TICK);
  assign push   = accept && (req.req_type == REQ_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_low <= START_LOW_RST;
      regs.short_ph  <= SHORT_RST;
      regs.long_ph   <= LONG_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        REG_START_LOW: regs.start_low <= cfg.data;
        REG_SHORT:     regs.short_ph  <= cfg.data;
        REG_LONG:      regs.long_ph   <= cfg.data;
        default:       ;
      endcase
    end
  end

  pwow_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_byte (req.write_byte),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_byte (q_head_byte),
    .stat      (q_stat)
  );

  pwow_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .cfg         (regs),
    .q_not_empty (q_not_empty),
    .q_head_byte (q_head_byte),
    .pop         (pop),
    .stat        (fr_stat)
  );

  assign res.line_level   = fr_stat.line_next;
  assign res.sending      = fr_stat.sending_next;
  assign res.queued_count = QCOUNT_W'(q_stat.fill_next);
  assign res.dropped      = q_stat.dropped;

  pwow_outbuf u_outbuf (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (res),
    .space (space),
    .rsp   (rsp)
  );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: pulse width one-wire sender regression
// Drives byte writes and time ticks into the sender under changing phase
// lengths. A behavioral copy of the frame timing and of the byte queue
// predicts each result not typed into the table; all are checked field by field in arrival order.
// A short directed table runs first, then random bursts of writes and ticks
// under three idle schemes, then one frame at the largest phase lengths.
// ----------------------------------------------------------------------------
module tb;
  import pwow_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [REG_W-1:0]     REG_MAX    = 13'h1FFF;
  localparam bit ROW_ITEM = 1'b0;
  localparam bit ROW_CFG  = 1'b1;
  localparam int DIR_ROWS     = 26;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam int HOLD_CYCLES  = 48;
  localparam int SETTLE       = 2;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] addr;
    logic [REG_W-1:0]     data;
    logic                 kind;
    logic [BYTE_W-1:0]    wbyte;
    bit                   typed;
    result_t              want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  pwow_req_if req ();
  pwow_rsp_if rsp ();
  pwow_cfg_if cfg ();

  pulse_width_one_wire_sender i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  // shadow of the sender: phase lengths, byte queue and frame timing
  cfg_t               phase_len;
  logic [BYTE_W-1:0]  q_mem [QUEUE_DEPTH];
  logic [QA_W-1:0]    q_head;
  logic [QA_W-1:0]    q_tail;
  logic [FILL_W-1:0]  q_fill;
  phase_t             frame_ph;
  logic [BIT_W-1:0]   bit_idx;
  logic [BYTE_W-1:0]  shifter;
  logic [CNT_W-1:0]   ph_cnt;
  logic               line_q;

  result_t pending_results [$];

  int mismatches   = 0;
  int sent         = 0;
  int checked      = 0;
  int drops        = 0;
  int frames       = 0;
  int reg_writes   = 0;
  int send_idle_pct = 0;
  int rsp_idle_pct  = 0;
  bit hold_off_req  = 1'b0;

  // directed table, reset phase lengths 5000 / 200 / 600 at the top
  step_row_t script [DIR_ROWS] = '{
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b1, '{1'b1, 1'b0, 6'd0, 1'b0}},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_WRITE, 8'h00, 1'b1, '{1'b1, 1'b0, 6'd1, 1'b0}},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_WRITE, 8'hFF, 1'b1, '{1'b1, 1'b0, 6'd2, 1'b0}},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b1, '{1'b0, 1'b1, 6'd1, 1'b0}},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b1, '{1'b0, 1'b1, 6'd1, 1'b0}},
    // start pulse already past its new length
    '{ROW_CFG, REG_START_LOW, 13'd1, REQ_TICK, 8'h00, 1'b0, '0},
    // zero length short phase
    '{ROW_CFG, REG_SHORT, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_CFG, REG_LONG, 13'd2, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_CFG, REG_UNUSED, REG_MAX, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_WRITE, 8'h80, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_WRITE, 8'h7F, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_WRITE, 8'h01, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'hFF, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_CFG, REG_SHORT, REG_MAX, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_WRITE, 8'h55, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_CFG, REG_SHORT, 13'd1, REQ_TICK, 8'h00, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 13'd0, REQ_TICK, 8'h00, 1'b0, '0}
  };

  function automatic bit phase_expired(input logic [REG_W-1:0] dur);
    ph_cnt = ph_cnt + 1'b1;
    return ph_cnt >= dur;
  endfunction

  // line, sending flag and queue fill after one request
  function automatic result_t frame_step(input logic kind, input logic [BYTE_W-1:0] wb);
    result_t r;
    logic    one;
    logic    drop;
    one  = shifter[0];
    drop = 1'b0;
    if (kind == REQ_WRITE) begin
      if (q_fill == FILL_W'(QUEUE_DEPTH)) begin
        drop = 1'b1;
      end else begin
        q_mem[q_tail] = wb;
        q_tail = q_tail + 1'b1;
        q_fill = q_fill + 1'b1;
      end
    end else begin
      case (frame_ph)
        PH_IDLE: begin
          if (q_fill != '0) begin
            shifter  = q_mem[q_head];
            q_head   = q_head + 1'b1;
            q_fill   = q_fill - 1'b1;
            frame_ph = PH_START;
            ph_cnt   = '0;
            bit_idx  = '0;
            line_q   = 1'b0;
            frames++;
          end
        end
        PH_START: begin
          if (phase_expired(phase_len.start_low)) begin
            frame_ph = PH_HIGH;
            ph_cnt   = '0;
            bit_idx  = '0;
            line_q   = 1'b1;
          end
        end
        PH_HIGH: begin
          if (phase_expired(one ? phase_len.long_ph : phase_len.short_ph)) begin
            frame_ph = PH_LOW;
            ph_cnt   = '0;
            line_q   = 1'b0;
          end
        end
        default: begin
          if (phase_expired(one ? phase_len.short_ph : phase_len.long_ph)) begin
            ph_cnt = '0;
            line_q = 1'b1;
            if (bit_idx == BIT_LAST) begin
              frame_ph = PH_IDLE;
              bit_idx  = '0;
            end else begin
              bit_idx  = bit_idx + 1'b1;
              shifter  = shifter >> 1;
              frame_ph = PH_HIGH;
            end
          end
        end
      endcase
    end
    r.line_level   = line_q;
    r.sending      = (frame_ph != PH_IDLE);
    r.queued_count = QCOUNT_W'(q_fill);
    r.dropped      = drop;
    if (drop) drops++;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic offer(input logic kind, input logic [BYTE_W-1:0] wb,
                       input bit typed, input result_t want);
    result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.write_byte <= wb;
    do @(posedge clk); while (req.ready !== 1'b1);
    predicted = frame_step(kind, wb);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.addr  <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    case (idx)
      REG_START_LOW: phase_len.start_low = val;
      REG_SHORT:     phase_len.short_ph  = val;
      REG_LONG:      phase_len.long_ph   = val;
      default:       ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [REG_W-1:0] pick_len();
    return ($urandom_range(5) == 0) ? REG_W'(1) : REG_W'($urandom_range(1, 6));
  endfunction

  // result side: random stalls plus one long counted hold-off on request
  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        stall_left   = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    result_t got;
    result_t want;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got.line_level   = rsp.line_level;
      got.sending      = rsp.sending;
      got.queued_count = rsp.queued_count;
      got.dropped      = rsp.dropped;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "result %0d got/want line %b/%b sending %b/%b count %0d/%0d dropped %b/%b",
            checked, got.line_level, want.line_level, got.sending, want.sending,
            got.queued_count, want.queued_count, got.dropped, want.dropped));
        checked++;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("pulse_width_one_wire_sender regression: fail");
    $finish;
  end

  initial begin : stimulus
    int n;
    int burst;
    int sel;
    bit mid_drain;
    mid_drain = 1'b0;
    phase_len = '{START_LOW_RST, SHORT_RST, LONG_RST};
    q_head    = '0;
    q_tail    = '0;
    q_fill    = '0;
    frame_ph  = PH_IDLE;
    bit_idx   = '0;
    shifter   = '0;
    ph_cnt    = '0;
    line_q    = 1'b1;

    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_TICK;
    req.write_byte <= '0;
    cfg.valid      <= 1'b0;
    cfg.addr       <= REG_START_LOW;
    cfg.data       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].addr, script[i].data);
      else offer(script[i].kind, script[i].wbyte, script[i].typed, script[i].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      send_idle_pct = (p < 3) ? 30 : (p < 6) ? 70 : 0;
      rsp_idle_pct  = (p < 3) ? 70 : (p < 6) ? 30 : 0;
      write_reg(REG_START_LOW, pick_len());
      write_reg(REG_SHORT, pick_len());
      write_reg(REG_LONG, pick_len());
      // long result stall while requests keep coming, so the input backs up
      if (p == 6) hold_off_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (p == 4 && !mid_drain && n >= PHASE_ITEMS / 2) begin
          wait_drained();
          mid_drain = 1'b1;
        end
        sel = $urandom_range(9);
        if (sel < 3) begin
          burst = (sel == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
          repeat (burst) offer(REQ_WRITE, BYTE_W'($urandom), 1'b0, '0);
        end else if (sel < 8) begin
          burst = $urandom_range(1, 40);
          repeat (burst) offer(REQ_TICK, BYTE_W'($urandom), 1'b0, '0);
        end else begin
          burst = 1;
          offer(1'($urandom), BYTE_W'($urandom), 1'b0, '0);
        end
        n += burst;
      end
    end

    // one frame at the largest phase lengths, cut short by a mid-phase rewrite
    write_reg(REG_START_LOW, REG_MAX);
    write_reg(REG_SHORT, REG_MAX);
    write_reg(REG_LONG, REG_MAX);
    offer(REQ_WRITE, 8'h5A, 1'b0, '0);
    repeat (40) offer(REQ_TICK, 8'h00, 1'b0, '0);
    write_reg(REG_START_LOW, 13'd1);
    write_reg(REG_SHORT, 13'd1);
    write_reg(REG_LONG, 13'd1);
    repeat (40) offer(REQ_TICK, 8'h00, 1'b0, '0);

    wait_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d requests, %0d frames started, %0d writes dropped on a full queue",
             sent, frames, drops);
    $display("checked %0d results after %0d register writes, %0d mismatches",
             checked, reg_writes, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pulse_width_one_wire_sender regression: pass");
    end else begin
      $display("pulse_width_one_wire_sender regression: fail");
    end
    $finish;
  end

endmodule
